@@ sv/tpd_pkg.sv @@
// Shared types and codes for the telemetry packet deframer.
// No dependencies; imported by tpd_crc16, tpd_parser and telemetry_packet_deframer.
package tpd_pkg;

  localparam int ID_LEN_DEF = 16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    KIND_ID   = 2'd0,
    KIND_PAY  = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_ABORT = 2'd2
  } status_t;

  // One result transaction as handed from the parser to the output register
  typedef struct packed {
    logic [7:0]         data_byte;
    kind_t              byte_kind;
    logic signed [31:0] packet_type;
    logic signed [31:0] payload_length;
    logic               last;
    status_t            status;
  } res_t;

endpackage

@@ sv/tpd_crc16.sv @@
// Byte-wide CRC-16/MODBUS update (reflected polynomial, no final xor).
// Depends on tpd_pkg for the polynomial constant.
module tpd_crc16 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import tpd_pkg::*;

  // Fold in the byte, then shift out eight bits
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

@@ sv/tpd_parser.sv @@
// Packet header parser and sequencer: holds phase, counters, header words and CRC.
// Depends on tpd_pkg and tpd_crc16.
module tpd_parser #(
  parameter int ID_LEN = tpd_pkg::ID_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic        abort,
  output logic        res_valid,
  output tpd_pkg::res_t res
);
  import tpd_pkg::*;

  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_LEN  = 3'd1,
    PH_CRC  = 3'd2,
    PH_ID   = 3'd3,
    PH_PAY  = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] len_r, len_nxt;
  logic [15:0] exp_crc_r, exp_crc_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_upd;
  logic        phase_ok;
  logic        start;
  logic [31:0] cnt_inc;
  logic        len_pos;

  tpd_crc16 u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .crc_out (crc_upd)
  );

  assign phase_ok = (phase_r == PH_TYPE) || (phase_r == PH_LEN) || (phase_r == PH_CRC) ||
                    (phase_r == PH_ID) || (phase_r == PH_PAY);
  // Start of a new packet: first type byte, or a stray phase code
  assign start    = !phase_ok || ((phase_r == PH_TYPE) && (cnt_r == 32'd0));
  assign cnt_inc  = (start ? 32'd0 : cnt_r) + 32'd1;
  assign len_pos  = !len_r[31] && (len_r != 32'd0);

  // Next state and result for one accepted byte
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    type_nxt    = type_r;
    len_nxt     = len_r;
    exp_crc_nxt = exp_crc_r;
    crc_nxt     = crc_r;
    res_valid   = 1'b0;
    res.data_byte      = rx_byte;
    res.byte_kind      = KIND_ID;
    res.packet_type    = type_r;
    res.payload_length = len_r;
    res.last           = 1'b0;
    res.status         = ST_OK;
    if (step) begin
      if (abort) begin
        if (!start) begin
          res_valid      = 1'b1;
          res.data_byte  = 8'h00;
          res.byte_kind  = KIND_NONE;
          res.last       = 1'b1;
          res.status     = ST_ABORT;
          phase_nxt   = PH_TYPE;
          cnt_nxt     = 32'd0;
          type_nxt    = 32'd0;
          len_nxt     = 32'd0;
          exp_crc_nxt = 16'd0;
          crc_nxt     = CRC_INIT;
        end else begin
          phase_nxt = PH_TYPE;
          cnt_nxt   = 32'd0;
        end
      end else begin
        unique case (phase_r)
          PH_LEN: begin
            len_nxt = {len_r[23:0], rx_byte};
            if (cnt_inc >= 32'd4) begin
              phase_nxt = PH_CRC;
              cnt_nxt   = 32'd0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_CRC: begin
            exp_crc_nxt = {exp_crc_r[7:0], rx_byte};
            if (cnt_inc >= 32'd2) begin
              phase_nxt = PH_ID;
              cnt_nxt   = 32'd0;
              crc_nxt   = CRC_INIT;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_ID: begin
            res_valid = 1'b1;
            if (cnt_inc >= 32'(ID_LEN)) begin
              cnt_nxt = 32'd0;
              if (!len_pos) begin
                res.last    = 1'b1;
                phase_nxt   = PH_TYPE;
                type_nxt    = 32'd0;
                len_nxt     = 32'd0;
                exp_crc_nxt = 16'd0;
                crc_nxt     = CRC_INIT;
              end else begin
                phase_nxt = PH_PAY;
              end
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_PAY: begin
            res_valid     = 1'b1;
            res.byte_kind = KIND_PAY;
            crc_nxt       = crc_upd;
            if (cnt_inc >= len_r) begin
              res.last    = 1'b1;
              res.status  = (crc_upd == exp_crc_r) ? ST_OK : ST_BAD;
              phase_nxt   = PH_TYPE;
              cnt_nxt     = 32'd0;
              type_nxt    = 32'd0;
              len_nxt     = 32'd0;
              exp_crc_nxt = 16'd0;
              crc_nxt     = CRC_INIT;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          default: begin
            // Type phase, also taken for stray phase codes
            type_nxt  = {(start ? 24'd0 : type_r[23:0]), rx_byte};
            if (start) begin
              len_nxt     = 32'd0;
              exp_crc_nxt = 16'd0;
              crc_nxt     = CRC_INIT;
            end
            if (cnt_inc >= 32'd4) begin
              phase_nxt = PH_LEN;
              cnt_nxt   = 32'd0;
            end else begin
              phase_nxt = PH_TYPE;
              cnt_nxt   = cnt_inc;
            end
          end
        endcase
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TYPE;
      cnt_r     <= 32'd0;
      type_r    <= 32'd0;
      len_r     <= 32'd0;
      exp_crc_r <= 16'd0;
      crc_r     <= CRC_INIT;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      type_r    <= type_nxt;
      len_r     <= len_nxt;
      exp_crc_r <= exp_crc_nxt;
      crc_r     <= crc_nxt;
    end
  end

endmodule

@@ sv/telemetry_packet_deframer.sv @@
// Telemetry packet deframer: an accepted byte's result shows in the next cycle.
// One byte per cycle unless out_ready stalls; parser next state and byte-wide CRC update
// are combinational, and the output register takes a new result while the last is taken.
// Reset (rst_n, synchronous): parser waits for a type word, CRC at 0xFFFF, no result held.
// Depends on tpd_pkg and tpd_parser.
module telemetry_packet_deframer #(
  parameter int ID_LEN = tpd_pkg::ID_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_abort,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_data_byte,
  output logic [1:0]         out_byte_kind,
  output logic signed [31:0] out_packet_type,
  output logic signed [31:0] out_payload_length,
  output logic               out_last,
  output logic [1:0]         out_status
);
  import tpd_pkg::*;

  logic step;
  logic res_valid;
  res_t res;
  logic out_valid_r;
  res_t out_res_r;

  // Accept whenever the output register is free or being emptied
  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  tpd_parser #(
    .ID_LEN (ID_LEN)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_rx_byte),
    .abort     (in_abort),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data_byte      = out_res_r.data_byte;
  assign out_byte_kind      = out_res_r.byte_kind;
  assign out_packet_type    = out_res_r.packet_type;
  assign out_payload_length = out_res_r.payload_length;
  assign out_last           = out_res_r.last;
  assign out_status         = out_res_r.status;

`ifndef NO_ASSERTIONS
  a_abort_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte_kind == KIND_NONE) |-> out_last && (out_status == ST_ABORT))
    else $error("abort report without last or aborted status");

  a_mid_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> (out_status == ST_OK))
    else $error("status set on a non-final result");

  a_pay_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte_kind == KIND_PAY) |-> (out_payload_length > 0))
    else $error("payload byte with non-positive length");

  a_no_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !in_valid |=> !out_valid)
    else $error("result repeated after completed transaction");
`endif

endmodule

@@ sim/telemetry_packet_deframer_tb.sv @@
// Self-checking testbench for telemetry_packet_deframer: random framed byte streams
// with bursty input and a stalling output, each result checked against a local predictor.
// Depends on tpd_pkg and telemetry_packet_deframer.
module telemetry_packet_deframer_tb;
  import tpd_pkg::*;

  localparam int ID_BYTES    = ID_LEN_DEF;
  localparam int RANDOM_ITEMS = 1850;

  typedef enum logic [2:0] {SEG_TYPE, SEG_LEN, SEG_CRC, SEG_ID, SEG_PAY} seg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       abort;
  } rx_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               in_abort = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_data_byte;
  logic [1:0]         out_byte_kind;
  logic signed [31:0] out_packet_type;
  logic signed [31:0] out_payload_length;
  logic               out_last;
  logic [1:0]         out_status;

  // Byte stream waiting to be sent, and results predicted but not yet seen
  rx_item_t stream_q[$];
  res_t     predicted_q[$];
  int       stream_total;
  int       ignored_items;
  int       accepted_count;
  bit       mismatch_seen;

  // Predictor state of the deframer
  seg_t        seg;
  logic [31:0] seg_count;
  logic [31:0] hold_type;
  logic [31:0] hold_len;
  logic [15:0] hold_crc;
  logic [15:0] run_crc;

  // Sender and receiver pacing
  rx_item_t    next_item;
  int          burst_left;
  int          gap_left;
  logic [15:0] ready_pat;
  int          ready_age;
  res_t        want;

  telemetry_packet_deframer #(.ID_LEN(ID_BYTES)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .in_abort          (in_abort),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_byte     (out_data_byte),
    .out_byte_kind     (out_byte_kind),
    .out_packet_type   (out_packet_type),
    .out_payload_length(out_payload_length),
    .out_last          (out_last),
    .out_status        (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // CRC-16/MODBUS, one byte, reflected
  function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void restart_packet();
    seg       = SEG_TYPE;
    seg_count = 32'd0;
    hold_type = 32'd0;
    hold_len  = 32'd0;
    hold_crc  = 16'h0000;
    run_crc   = CRC_INIT;
  endfunction

  function automatic void push_expected(logic [7:0] b, kind_t k, logic lst, status_t st);
    res_t r;
    r.data_byte      = b;
    r.byte_kind      = k;
    r.packet_type    = hold_type;
    r.payload_length = hold_len;
    r.last           = lst;
    r.status         = st;
    predicted_q.push_back(r);
  endfunction

  // Advance the predictor by one accepted byte or abort
  function automatic void deframe_step(logic [7:0] b, logic ab);
    if (ab) begin
      // an abort between packets leaves everything as it is
      if (seg == SEG_TYPE && seg_count == 0) return;
      push_expected(8'h00, KIND_NONE, 1'b1, ST_ABORT);
      restart_packet();
      return;
    end
    if (seg == SEG_TYPE && seg_count == 0) restart_packet();
    case (seg)
      SEG_TYPE: begin
        hold_type = {hold_type[23:0], b};
        seg_count++;
        if (seg_count >= 4) begin
          seg = SEG_LEN;
          seg_count = 0;
        end
      end
      SEG_LEN: begin
        hold_len = {hold_len[23:0], b};
        seg_count++;
        if (seg_count >= 4) begin
          seg = SEG_CRC;
          seg_count = 0;
        end
      end
      SEG_CRC: begin
        hold_crc = {hold_crc[7:0], b};
        seg_count++;
        if (seg_count >= 2) begin
          seg = SEG_ID;
          seg_count = 0;
          run_crc = CRC_INIT;
        end
      end
      SEG_ID: begin
        seg_count++;
        if (seg_count >= ID_BYTES) begin
          // no payload when the length is zero or negative: close on the last id byte
          if (hold_len[31] || hold_len == 0) begin
            push_expected(b, KIND_ID, 1'b1, ST_OK);
            restart_packet();
            return;
          end
          seg = SEG_PAY;
          seg_count = 0;
        end
        push_expected(b, KIND_ID, 1'b0, ST_OK);
      end
      default: begin
        run_crc = crc16_step(run_crc, b);
        seg_count++;
        if (seg_count >= hold_len) begin
          push_expected(b, KIND_PAY, 1'b1, (run_crc == hold_crc) ? ST_OK : ST_BAD);
          restart_packet();
        end else begin
          push_expected(b, KIND_PAY, 1'b0, ST_OK);
        end
      end
    endcase
  endfunction

  task automatic push_rx(input logic [7:0] b, input logic ab);
    rx_item_t it;
    it.rx_byte = b;
    it.abort   = ab;
    stream_q.push_back(it);
  endtask

  // Queue one packet. cut >= 0 sends that many bytes and then an abort;
  // fill >= 0 sets every identifier and payload byte to that value.
  task automatic queue_packet(input logic [31:0] ptype, input logic [31:0] plen,
                              input int n_pay, input bit crc_good, input int cut,
                              input int fill);
    logic [7:0]  body[$];
    logic [7:0]  frame[$];
    logic [15:0] crc;
    logic [7:0]  b;
    crc = CRC_INIT;
    for (int i = 0; i < ID_BYTES + n_pay; i++) begin
      b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      body.push_back(b);
      if (i >= ID_BYTES) crc = crc16_step(crc, b);
    end
    if (!crc_good) crc = crc ^ 16'($urandom_range(1, 65535));
    for (int i = 3; i >= 0; i--) frame.push_back(ptype[8*i +: 8]);
    for (int i = 3; i >= 0; i--) frame.push_back(plen[8*i +: 8]);
    frame.push_back(crc[15:8]);
    frame.push_back(crc[7:0]);
    foreach (body[i]) frame.push_back(body[i]);
    if (cut < 0) begin
      foreach (frame[i]) push_rx(frame[i], 1'b0);
    end else begin
      for (int i = 0; i < cut; i++) push_rx(frame[i], 1'b0);
      push_rx(8'($urandom_range(0, 255)), 1'b1);
      if (cut == 0) ignored_items++;
    end
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, got_v);
      mismatch_seen = 1'b1;
    end
  endfunction

  // Driver: send bursts from the stream queue, predict on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(1, 48);
      gap_left   = 0;
    end else begin
      if (in_valid && in_ready) begin
        deframe_step(in_rx_byte, in_abort);
        accepted_count++;
      end
      if (in_valid && !in_ready) begin
        // hold the transaction until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stream_q.size() > 0) begin
        next_item = stream_q.pop_front();
        in_valid   <= 1'b1;
        in_rx_byte <= next_item.rx_byte;
        in_abort   <= next_item.abort;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transaction and drive the stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_pat = 16'hFFFF;
      ready_age = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_q.size() == 0) begin
          $error("result with none expected: data_byte %0h, byte_kind %0d",
                 out_data_byte, out_byte_kind);
          mismatch_seen = 1'b1;
        end else begin
          want = predicted_q.pop_front();
          check_field("data_byte", 32'(want.data_byte), 32'(out_data_byte));
          check_field("byte_kind", 32'(want.byte_kind), 32'(out_byte_kind));
          check_field("packet_type", want.packet_type, out_packet_type);
          check_field("payload_length", want.payload_length, out_payload_length);
          check_field("last", 32'(want.last), 32'(out_last));
          check_field("status", 32'(want.status), 32'(out_status));
        end
      end
      // reload the pattern now and then; a quarter of the time never stall
      ready_age++;
      if (ready_age >= 48) begin
        ready_age = 0;
        ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      ready_pat = {ready_pat[0], ready_pat[15:1]};
      out_ready <= ready_pat[0];
    end
  end

  // Stimulus and end of run
  initial begin
    int          sel;
    int          n;
    logic [31:0] ptype;
    logic [31:0] plen;
    restart_packet();
    ignored_items  = 0;
    accepted_count = 0;
    mismatch_seen  = 1'b0;

    // directed: idle abort, empty and negative lengths, extremes, bad CRC, aborts per field
    queue_packet(32'h0, 32'h0, 0, 1'b1, 0, -1);
    queue_packet(32'h0000_0000, 32'h0000_0000, 0, 1'b1, -1, 0);
    queue_packet(32'hFFFF_FFFF, 32'h8000_0000, 0, 1'b1, -1, 255);
    queue_packet(32'h7FFF_FFFF, 32'h0000_0001, 1, 1'b1, -1, 0);
    queue_packet(32'h8000_0000, 32'h0000_0003, 3, 1'b0, -1, 255);
    queue_packet(32'hA5C3_3C5A, 32'h0000_0005, 5, 1'b1, -1, -1);
    queue_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b1, -1, -1);
    queue_packet($urandom, 32'h4, 4, 1'b1, 1, -1);
    queue_packet($urandom, 32'h4, 4, 1'b1, 6, -1);
    queue_packet($urandom, 32'h4, 4, 1'b1, 9, -1);
    queue_packet($urandom, 32'h4, 4, 1'b1, 14, -1);
    queue_packet($urandom, 32'h8, 8, 1'b1, 10 + ID_BYTES + 3, -1);
    queue_packet(32'h0, 32'h0, 0, 1'b1, 0, -1);

    // random: mostly well-formed packets, mixed with bad CRCs, long lengths and cut packets
    while (stream_q.size() - ignored_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: ptype = 32'h0000_0000;
          1: ptype = 32'hFFFF_FFFF;
          2: ptype = 32'h7FFF_FFFF;
          default: ptype = 32'h8000_0000;
        endcase
      end else begin
        ptype = $urandom;
      end
      n = $urandom_range(1, 24);
      if (sel < 55) begin
        queue_packet(ptype, n, n, 1'b1, -1, -1);
      end else if (sel < 65) begin
        queue_packet(ptype, n, n, 1'b0, -1, -1);
      end else if (sel < 75) begin
        plen = ($urandom_range(0, 2) == 0) ? 32'h0 : ($urandom | 32'h8000_0000);
        queue_packet(ptype, plen, 0, 1'b1, -1, -1);
      end else if (sel < 83) begin
        // length far beyond what is sent: drop it part way through the payload
        plen = ($urandom & 32'h7FFF_FFFF) | 32'h0000_0100;
        n = $urandom_range(0, 8);
        queue_packet(ptype, plen, n, 1'b1, 10 + ID_BYTES + n, -1);
      end else if (sel < 96) begin
        queue_packet(ptype, n, n, 1'($urandom_range(0, 1)),
                     $urandom_range(1, 9 + ID_BYTES + n), -1);
      end else begin
        queue_packet(ptype, 32'h0, 0, 1'b1, 0, -1);
      end
    end
    stream_total = stream_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < stream_total) @(posedge clk);
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (!mismatch_seen) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
sv/tpd_pkg.sv
sv/tpd_crc16.sv
sv/tpd_parser.sv
sv/telemetry_packet_deframer.sv
sim/telemetry_packet_deframer_tb.sv
